### design/stiru_pkg.sv
// Shared types and constants for the sorted table insert/remove unit.
`timescale 1ns / 1ps

package stiru_pkg;

	// Field widths fixed by the item format
	localparam int unsigned DATA_W    = 32;
	localparam int unsigned CNT_OUT_W = 7;

	// Command codes
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	// Per-cycle control broadcast from the sequencer to every cell
	typedef struct packed {
		logic cmp_en;   // latch compare flags against the incoming value
		logic ins_en;   // apply a successful insert (shift toward the tail)
		logic rem_en;   // apply a successful remove (shift toward the head)
	} cell_ctl_t;

endpackage

### design/stiru_cmd_if.sv
// Command channel: one insert or remove beat per handshake.
`timescale 1ns / 1ps

interface stiru_cmd_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   command;
	logic signed [stiru_pkg::DATA_W-1:0]    value;

	modport source (output valid, output command, output value, input ready);
	modport sink   (input valid, input command, input value, output ready);
endinterface

### design/stiru_res_if.sv
// Result channel: status and fill level for each command beat.
`timescale 1ns / 1ps

interface stiru_res_if;
	logic                                valid;
	logic                                ready;
	logic                                ok;
	logic [stiru_pkg::CNT_OUT_W-1:0]     count;
	logic                                empty_res;

	modport source (output valid, output ok, output count, output empty_res, input ready);
	modport sink   (input valid, input ok, input count, input empty_res, output ready);
endinterface

### design/sorted_table_insert_remove_unit.sv
// Top level of the sorted table insert/remove unit: sequencer and chain of cells.
`timescale 1ns / 1ps
//
// Keeps up to CAPACITY signed 32-bit entries in ascending order in a row of
// cells. Each cmd beat carries a command (insert or remove) and a value; each
// produces exactly one res beat with ok, the entry count after the command and
// an empty flag. Inserts go ahead of equal entries; removes take the first
// equal entry. A full table on insert, or an empty table or absent value on
// remove, leaves the table unchanged and returns ok = 0.
// Timing: in the accept cycle every cell compares its entry with the value at
// once and latches the flags; in the APPLY state the cells from the insert or
// remove point on shift one place in parallel and the result register is
// loaded. A new cmd beat is taken only after the last has left APPLY. The
// result register frees cmd from res: the next command is accepted while a
// result still waits. If res stalls, the shift step holds until the waiting
// result is taken. Reset clears the entry count and the handshake state; no
// clearing pass is needed, so cmd is ready right away.
//
module sorted_table_insert_remove_unit #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	stiru_cmd_if.sink    cmd,
	stiru_res_if.source  res
);

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam int unsigned EXT_W = CNT_W + stiru_pkg::CNT_OUT_W;

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_APPLY = 1'b1;

	logic                                state_q;
	logic                                command_q;
	logic signed [stiru_pkg::DATA_W-1:0] key_q;
	logic [CNT_W-1:0]                    count_q;
	logic                                res_valid_q;
	logic                                res_ok_q;
	logic [stiru_pkg::CNT_OUT_W-1:0]     res_count_q;
	logic                                res_empty_q;

	stiru_pkg::cell_ctl_t                ctl;
	logic signed [stiru_pkg::DATA_W-1:0] cell_value [CAPACITY];
	logic [CAPACITY-1:0]                 cell_lt;
	logic [CAPACITY-1:0]                 cell_hit;
	logic                                accept;
	logic                                apply_go;
	logic                                full;
	logic                                found;
	logic                                ins_ok;
	logic                                rem_ok;
	logic [CNT_W-1:0]                    count_next;
	logic [EXT_W-1:0]                    count_ext;

	// Handshake and step control
	assign cmd.ready = (state_q == ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign apply_go  = (state_q == ST_APPLY) && (!res_valid_q || res.ready);

	assign full   = (count_q == CNT_W'(CAPACITY));
	assign found  = |cell_hit;
	assign ins_ok = (command_q == stiru_pkg::CMD_INSERT) && !full;
	assign rem_ok = (command_q == stiru_pkg::CMD_REMOVE) && found;

	assign ctl.cmp_en = accept;
	assign ctl.ins_en = apply_go && ins_ok;
	assign ctl.rem_en = apply_go && rem_ok;

	always_comb begin
		count_next = count_q;
		if (ins_ok) begin
			count_next = count_q + CNT_W'(1);
		end else if (rem_ok) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	assign count_ext = EXT_W'(count_next);

	// Sequencer and stored count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					if (apply_go) begin
						state_q <= ST_IDLE;
						count_q <= count_next;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Command beat capture
	always_ff @(posedge clk) begin
		if (accept) begin
			command_q <= cmd.command;
			key_q     <= cmd.value;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (apply_go) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply_go) begin
			res_ok_q    <= ins_ok || rem_ok;
			res_count_q <= count_ext[stiru_pkg::CNT_OUT_W-1:0];
			res_empty_q <= (count_next == '0);
		end
	end

	assign res.valid     = res_valid_q;
	assign res.ok        = res_ok_q;
	assign res.count     = res_count_q;
	assign res.empty_res = res_empty_q;

	// Chain of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                                occupied;
		logic signed [stiru_pkg::DATA_W-1:0] left_value;
		logic                                left_lt;
		logic signed [stiru_pkg::DATA_W-1:0] right_value;

		assign occupied = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_head
			assign left_value = '0;
			assign left_lt    = 1'b1;
		end else begin : g_body
			assign left_value = cell_value[i-1];
			assign left_lt    = cell_lt[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_value = cell_value[i];
		end else begin : g_inner
			assign right_value = cell_value[i+1];
		end

		stiru_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.occupied    (occupied),
			.key         (accept ? cmd.value : key_q),
			.left_value  (left_value),
			.left_lt     (left_lt),
			.right_value (right_value),
			.value       (cell_value[i]),
			.lt          (cell_lt[i]),
			.hit         (cell_hit[i])
		);
	end

endmodule

### design/stiru_cell.sv
// One slot of the sorted table: holds an entry, compares it, shifts with its neighbors.
`timescale 1ns / 1ps

module stiru_cell (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  stiru_pkg::cell_ctl_t                 ctl,
	input  logic                                 occupied,
	input  logic signed [stiru_pkg::DATA_W-1:0]  key,
	input  logic signed [stiru_pkg::DATA_W-1:0]  left_value,
	input  logic                                 left_lt,
	input  logic signed [stiru_pkg::DATA_W-1:0]  right_value,
	output logic signed [stiru_pkg::DATA_W-1:0]  value,
	output logic                                 lt,
	output logic                                 hit
);

	logic signed [stiru_pkg::DATA_W-1:0] value_q;
	logic                                lt_q;
	logic                                eq_q;

	// Compare flags, taken when a command beat is accepted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (ctl.cmp_en) begin
			lt_q <= occupied && (value_q < key);
			eq_q <= occupied && (value_q == key);
		end
	end

	// Entry storage: keep, take the key, or take a neighbor's entry
	always_ff @(posedge clk) begin
		if (ctl.ins_en && !lt_q) begin
			value_q <= left_lt ? key : left_value;
		end else if (ctl.rem_en && !lt_q) begin
			value_q <= right_value;
		end
	end

	// First not-smaller slot that equals the key
	assign hit   = eq_q && left_lt;
	assign value = value_q;
	assign lt    = lt_q;

endmodule
